@@ rtl/core/button_press_hold_sequence_detector_assert.svh @@
// Assertion macros for the button press/hold sequence detector.
// Both macros assume the including module has aclk and aresetn in scope.
`ifndef BUTTON_PRESS_HOLD_SEQUENCE_DETECTOR_ASSERT_SVH
`define BUTTON_PRESS_HOLD_SEQUENCE_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define BPHSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bphsd assertion failed");

// Next-cycle implication, checked outside reset.
`define BPHSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bphsd assertion failed");

`else

`define BPHSD_ASSERT_NOW(lbl, ante, cons)
`define BPHSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/bphsd_pkg.sv @@
`default_nettype none

package bphsd_pkg;

    localparam int NOW_W       = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [7:0] PRESS_COUNT_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_DELAY   = 3'd0,
        REG_INVERT_LEVEL   = 3'd1,
        REG_PRESS_SEQ_CNT  = 3'd2,
        REG_SEQ_WINDOW     = 3'd3,
        REG_HOLD_THRESHOLD = 3'd4,
        REG_HOLD_ENABLED   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] filter_delay_ms;
        logic        invert_level;
        logic [7:0]  press_sequence_count;
        logic [15:0] sequence_window_ms;
        logic [15:0] hold_threshold_ms;
        logic        hold_enabled;
    } cfg_t;

    typedef struct packed {
        logic             current_level;
        logic [NOW_W-1:0] last_change_time;
        logic [7:0]       press_count;
        logic [NOW_W-1:0] first_press_time;
        logic             was_held;
        logic             hold_reported;
    } det_state_t;

    // level sits in the lowest bit
    typedef struct packed {
        logic hold_pulse;
        logic sequence_pulse;
        logic press_pulse;
        logic changed;
        logic level;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        filter_delay_ms:      16'd50,
        invert_level:         1'b0,
        press_sequence_count: 8'd2,
        sequence_window_ms:   16'd1000,
        hold_threshold_ms:    16'd1000,
        hold_enabled:         1'b1
    };

    localparam det_state_t STATE_RESET = '{
        current_level:    1'b0,
        last_change_time: '0,
        press_count:      8'd0,
        first_press_time: '0,
        was_held:         1'b0,
        hold_reported:    1'b0
    };

endpackage

`default_nettype wire

@@ rtl/core/bphsd_step.sv @@
`default_nettype none

// Next-state and result logic for one poll.
module bphsd_step (
    input  bphsd_pkg::cfg_t                   cfg,
    input  bphsd_pkg::det_state_t             state,
    input  logic [bphsd_pkg::NOW_W-1:0]       now_ms,
    input  logic                              raw_level,
    output bphsd_pkg::det_state_t             state_next,
    output bphsd_pkg::result_t                result
);
    import bphsd_pkg::*;

    logic             sample;
    logic [NOW_W-1:0] since_change;
    logic             filter_ok;
    logic             changed;
    logic             level_new;
    logic [NOW_W-1:0] hold_elapsed;
    logic             hold_hit;
    logic [NOW_W-1:0] first_time;
    logic [7:0]       count_inc;
    logic [NOW_W-1:0] seq_elapsed;
    logic [NOW_W-1:0] window_ext;

    // Filter: take the new level only after the lockout has passed
    assign sample       = raw_level ^ cfg.invert_level;
    assign since_change = now_ms - state.last_change_time;
    assign filter_ok    = since_change >= {16'd0, cfg.filter_delay_ms};
    assign changed      = filter_ok && (sample != state.current_level);
    assign level_new    = filter_ok ? sample : state.current_level;

    // Hold timing restarts at this poll when the level just changed
    assign hold_elapsed = changed ? '0 : since_change;
    assign hold_hit     = hold_elapsed >= {16'd0, cfg.hold_threshold_ms};

    // Press counting on release
    assign first_time  = (state.press_count == 8'd0) ? now_ms : state.first_press_time;
    assign count_inc   = (state.press_count < PRESS_COUNT_MAX) ?
                         state.press_count + 8'd1 : state.press_count;
    assign seq_elapsed = now_ms - first_time;
    assign window_ext  = {16'd0, cfg.sequence_window_ms};

    always_comb begin
        state_next                  = state;
        state_next.current_level    = level_new;
        result                      = '0;
        result.level                = level_new;
        result.changed              = changed;
        if (changed) begin
            state_next.last_change_time = now_ms;
        end

        if (!level_new && changed) begin
            if (!state.was_held) begin
                result.press_pulse          = 1'b1;
                state_next.press_count      = count_inc;
                state_next.first_press_time = first_time;
                if (count_inc == cfg.press_sequence_count && window_ext >= seq_elapsed) begin
                    result.sequence_pulse       = 1'b1;
                    state_next.press_count      = 8'd0;
                    state_next.first_press_time = '0;
                end else if (window_ext <= seq_elapsed) begin
                    state_next.press_count      = 8'd0;
                    state_next.first_press_time = '0;
                end
            end else begin
                state_next.was_held = 1'b0;
            end
            state_next.hold_reported = 1'b0;
        end else if (level_new && hold_hit && cfg.hold_enabled) begin
            // Hold: drop any pending presses, report once
            state_next.was_held         = 1'b1;
            state_next.press_count      = 8'd0;
            state_next.first_press_time = '0;
            if (!state.hold_reported) begin
                state_next.hold_reported = 1'b1;
                result.hold_pulse        = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/button_press_hold_sequence_detector.sv @@
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_        in         now_ms[31:0], raw_level, zero fill to 40 bits
// m_        out        level, changed, press_pulse, sequence_pulse, hold_pulse, zero fill
// cfg_      in         write only: cfg_wr_en, cfg_index, cfg_wdata
//
// One request per cycle sustained while the result is not stalled; each accepted
// request passes through the input register, then the result register.
// The detector state updates in the same cycle the result register loads,
// so consecutive polls see each other's effect with no bubble.
// Reset (aresetn low, synchronous) restores register defaults and clears state.
// A stalled result holds the result register; the input register then holds
// one more request before s_tready drops.
module button_press_hold_sequence_detector (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // now_ms[31:0], raw_level[32], zero [39:33]
    input  logic [bphsd_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // level[0], changed[1], press_pulse[2], sequence_pulse[3], hold_pulse[4], zero [7:5]
    output logic [bphsd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [bphsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bphsd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bphsd_pkg::*;

    `include "button_press_hold_sequence_detector_assert.svh"

    cfg_t             cfg_reg;
    det_state_t       state_reg;
    det_state_t       state_next;
    logic             in_valid_reg;
    logic [NOW_W-1:0] in_now_reg;
    logic             in_raw_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    result_t          res_next;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    bphsd_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .now_ms     (in_now_reg),
        .raw_level  (in_raw_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FILTER_DELAY:   cfg_reg.filter_delay_ms      <= cfg_wdata;
                REG_INVERT_LEVEL:   cfg_reg.invert_level         <= cfg_wdata[0];
                REG_PRESS_SEQ_CNT:  cfg_reg.press_sequence_count <= cfg_wdata[7:0];
                REG_SEQ_WINDOW:     cfg_reg.sequence_window_ms   <= cfg_wdata;
                REG_HOLD_THRESHOLD: cfg_reg.hold_threshold_ms    <= cfg_wdata;
                REG_HOLD_ENABLED:   cfg_reg.hold_enabled         <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: load when empty or draining into the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[NOW_W-1:0];
            in_raw_reg <= s_tdata[NOW_W];
        end
    end

    // Result register and detector state advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    `BPHSD_ASSERT_NOW(a_press_on_release, out_valid_reg && out_res_reg.press_pulse,
                      out_res_reg.changed && !out_res_reg.level)
    `BPHSD_ASSERT_NOW(a_seq_needs_press, out_valid_reg && out_res_reg.sequence_pulse,
                      out_res_reg.press_pulse)
    `BPHSD_ASSERT_NOW(a_hold_while_pressed, out_valid_reg && out_res_reg.hold_pulse,
                      out_res_reg.level && !out_res_reg.press_pulse)
    `BPHSD_ASSERT_NEXT(a_hold_marks_state, advance && res_next.hold_pulse,
                       state_reg.hold_reported && state_reg.was_held)
    `BPHSD_ASSERT_NEXT(a_seq_clears_count, advance && res_next.sequence_pulse,
                       state_reg.press_count == 8'd0)

endmodule

`default_nettype wire
